// ===== rtl/exsort_pkg.sv =====
// shared types and constants for the exchange sort block
// record layout as it is kept in the record memory and carried on the channels
package exsort_pkg;

    localparam int unsigned PRICE_W = 32;
    localparam int unsigned TAG_W   = 16;
    localparam int unsigned DAY_W   = 5;
    localparam int unsigned MONTH_W = 4;
    localparam int unsigned YEAR_W  = 14;
    localparam int unsigned TALLY_W = 7;

    localparam logic [MONTH_W-1:0] DECEMBER = 4'd12;

    typedef struct packed {
        logic signed [PRICE_W-1:0] price;
        logic [TAG_W-1:0]          tag;
        logic [DAY_W-1:0]          day;
        logic [MONTH_W-1:0]        month;
        logic [YEAR_W-1:0]         year;
    } t_rec;

    localparam int unsigned REC_W = $bits(t_rec);

endpackage

// ===== rtl/exsort_if.sv =====
// valid/ready channel interfaces for goods records in and sorted records out
// depends on exsort_pkg for field widths
interface exsort_in_if;
    logic                                    valid;
    logic                                    ready;
    logic signed [exsort_pkg::PRICE_W-1:0]   price;
    logic [exsort_pkg::TAG_W-1:0]            tag;
    logic [exsort_pkg::DAY_W-1:0]            day;
    logic [exsort_pkg::MONTH_W-1:0]          month;
    logic [exsort_pkg::YEAR_W-1:0]           year;
    logic                                    last_item;

    modport source (output valid, price, tag, day, month, year, last_item, input ready);
    modport sink   (input valid, price, tag, day, month, year, last_item, output ready);
endinterface

interface exsort_out_if;
    logic                                    valid;
    logic                                    ready;
    logic signed [exsort_pkg::PRICE_W-1:0]   sorted_price;
    logic [exsort_pkg::TAG_W-1:0]            sorted_tag;
    logic [exsort_pkg::DAY_W-1:0]            sorted_day;
    logic [exsort_pkg::MONTH_W-1:0]          sorted_month;
    logic [exsort_pkg::YEAR_W-1:0]           sorted_year;
    logic [exsort_pkg::TALLY_W-1:0]          december_count;
    logic                                    overflow;
    logic                                    end_of_list;

    modport source (output valid, sorted_price, sorted_tag, sorted_day, sorted_month,
                    sorted_year, december_count, overflow, end_of_list, input ready);
    modport sink   (input valid, sorted_price, sorted_tag, sorted_day, sorted_month,
                    sorted_year, december_count, overflow, end_of_list, output ready);
endinterface

// ===== rtl/exsort_ram.sv =====
// generic simple dual-port ram: one write port, one read port with registered data
// no dependencies
module exsort_ram #(
    parameter int unsigned WIDTH = 8,
    parameter int unsigned DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ===== rtl/exchange_sort_by_price.sv =====
// Collects goods records one word per cycle into a record memory of MAX_ITEMS entries;
// records past capacity are dropped and flagged. The word marked last_item starts an
// exchange sort by ascending signed price: entry i is held in a register while entries
// i+1..n-1 stream out of the memory's single read port, one compare per cycle. The sorted
// list then leaves through an output register: each word is read from the memory and then
// captured, carrying the month-12 count and the drop flag of its list. Loading of the next
// list may start while the final word of the previous list still waits to be taken.
// depends on exsort_pkg, exsort_if and exsort_ram
module exchange_sort_by_price #(
    parameter int unsigned MAX_ITEMS = 64
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    exsort_in_if.sink     i_in,
    exsort_out_if.source  o_out
);

    localparam int unsigned AW = $clog2(MAX_ITEMS);
    localparam int unsigned CW = $clog2(MAX_ITEMS + 1);

    typedef enum logic [6:0] {
        S_LOAD  = 7'b0000001,
        S_RD_I  = 7'b0000010,
        S_CUR   = 7'b0000100,
        S_SCAN  = 7'b0001000,
        S_WR_I  = 7'b0010000,
        S_E_RD  = 7'b0100000,
        S_E_CAP = 7'b1000000
    } t_state;

    t_state r_state, n_state;

    logic [CW-1:0] r_n, n_n;
    logic [CW-1:0] r_tally, n_tally;
    logic          r_drop, n_drop;
    logic [AW-1:0] r_i, n_i;
    logic [AW-1:0] r_j, n_j;
    logic [AW-1:0] r_k, n_k;
    exsort_pkg::t_rec r_cur, n_cur;

    logic          r_ov, n_ov;
    exsort_pkg::t_rec r_orec, n_orec;
    logic [exsort_pkg::TALLY_W-1:0] r_odec, n_odec;
    logic          r_oovf, n_oovf;
    logic          r_oeol, n_oeol;

    // memory ports
    logic                   w_we, w_re;
    logic [AW-1:0]          w_waddr, w_raddr;
    exsort_pkg::t_rec       w_wdata, w_rd, w_in_rec;
    logic [exsort_pkg::REC_W-1:0] w_rdata;

    logic          w_in_acc, w_out_acc, w_full, w_out_free;
    logic [CW-1:0] w_cnt_after, w_last_idx;

    exsort_ram #(
        .WIDTH (exsort_pkg::REC_W),
        .DEPTH (MAX_ITEMS)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (w_waddr),
        .i_wdata (w_wdata),
        .i_re    (w_re),
        .i_raddr (w_raddr),
        .o_rdata (w_rdata)
    );

    assign w_rd = w_rdata;

    assign w_in_rec.price = i_in.price;
    assign w_in_rec.tag   = i_in.tag;
    assign w_in_rec.day   = i_in.day;
    assign w_in_rec.month = i_in.month;
    assign w_in_rec.year  = i_in.year;

    assign i_in.ready  = (r_state == S_LOAD);
    assign w_in_acc    = i_in.valid && i_in.ready;
    assign w_out_acc   = r_ov && o_out.ready;
    assign w_out_free  = !r_ov || o_out.ready;
    assign w_full      = (r_n == CW'(MAX_ITEMS));
    assign w_cnt_after = w_full ? r_n : r_n + CW'(1);
    assign w_last_idx  = r_n - CW'(1);

    always_comb begin
        n_state = r_state;
        n_n     = r_n;
        n_tally = r_tally;
        n_drop  = r_drop;
        n_i     = r_i;
        n_j     = r_j;
        n_k     = r_k;
        n_cur   = r_cur;
        n_ov    = w_out_acc ? 1'b0 : r_ov;
        n_orec  = r_orec;
        n_odec  = r_odec;
        n_oovf  = r_oovf;
        n_oeol  = r_oeol;
        w_we    = 1'b0;
        w_waddr = r_j;
        w_wdata = r_cur;
        w_re    = 1'b0;
        w_raddr = r_j;

        case (r_state)
            S_LOAD: begin
                if (w_in_acc) begin
                    if (w_full) begin
                        n_drop = 1'b1;
                    end else begin
                        w_we    = 1'b1;
                        w_waddr = r_n[AW-1:0];
                        w_wdata = w_in_rec;
                        n_n     = r_n + CW'(1);
                        if (i_in.month == exsort_pkg::DECEMBER) begin
                            n_tally = r_tally + CW'(1);
                        end
                    end
                    if (i_in.last_item) begin
                        n_i = '0;
                        n_k = '0;
                        n_state = (w_cnt_after > CW'(1)) ? S_RD_I : S_E_RD;
                    end
                end
            end
            S_RD_I: begin
                w_re    = 1'b1;
                w_raddr = r_i;
                n_state = S_CUR;
            end
            S_CUR: begin
                // hold entry i, start streaming the later entries
                n_cur   = w_rd;
                w_re    = 1'b1;
                w_raddr = r_i + AW'(1);
                n_j     = r_i + AW'(1);
                n_state = S_SCAN;
            end
            S_SCAN: begin
                if (r_cur.price > w_rd.price) begin
                    w_we    = 1'b1;
                    w_waddr = r_j;
                    w_wdata = r_cur;
                    n_cur   = w_rd;
                end
                if (CW'(r_j) == w_last_idx) begin
                    n_state = S_WR_I;
                end else begin
                    w_re    = 1'b1;
                    w_raddr = r_j + AW'(1);
                    n_j     = r_j + AW'(1);
                end
            end
            S_WR_I: begin
                w_we    = 1'b1;
                w_waddr = r_i;
                w_wdata = r_cur;
                if (CW'(r_i) + CW'(2) == r_n) begin
                    n_state = S_E_RD;
                end else begin
                    n_i     = r_i + AW'(1);
                    n_state = S_RD_I;
                end
            end
            S_E_RD: begin
                w_re    = 1'b1;
                w_raddr = r_k;
                n_state = S_E_CAP;
            end
            S_E_CAP: begin
                if (w_out_free) begin
                    n_ov   = 1'b1;
                    n_orec = w_rd;
                    n_odec = exsort_pkg::TALLY_W'(r_tally);
                    n_oovf = r_drop;
                    n_oeol = (CW'(r_k) == w_last_idx);
                    if (CW'(r_k) == w_last_idx) begin
                        // list done, start a fresh one
                        n_n     = '0;
                        n_tally = '0;
                        n_drop  = 1'b0;
                        n_state = S_LOAD;
                    end else begin
                        n_k     = r_k + AW'(1);
                        n_state = S_E_RD;
                    end
                end
            end
            default: begin
                n_state = S_LOAD;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_LOAD;
            r_n     <= '0;
            r_tally <= '0;
            r_drop  <= 1'b0;
            r_i     <= '0;
            r_j     <= '0;
            r_k     <= '0;
            r_ov    <= 1'b0;
        end else begin
            r_state <= n_state;
            r_n     <= n_n;
            r_tally <= n_tally;
            r_drop  <= n_drop;
            r_i     <= n_i;
            r_j     <= n_j;
            r_k     <= n_k;
            r_ov    <= n_ov;
        end
    end

    always_ff @(posedge i_clk) begin
        r_cur  <= n_cur;
        r_orec <= n_orec;
        r_odec <= n_odec;
        r_oovf <= n_oovf;
        r_oeol <= n_oeol;
    end

    assign o_out.valid          = r_ov;
    assign o_out.sorted_price   = r_orec.price;
    assign o_out.sorted_tag     = r_orec.tag;
    assign o_out.sorted_day     = r_orec.day;
    assign o_out.sorted_month   = r_orec.month;
    assign o_out.sorted_year    = r_orec.year;
    assign o_out.december_count = r_odec;
    assign o_out.overflow       = r_oovf;
    assign o_out.end_of_list    = r_oeol;

    // a write never lands on the entry being read in the same cycle
    a_no_rw_collide: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_we && w_re) |-> (w_waddr != w_raddr))
        else $error("record memory read and write hit the same entry");

    a_fill_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_n <= CW'(MAX_ITEMS))
        else $error("fill count beyond capacity");

    a_tally_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_tally <= r_n)
        else $error("month-12 tally exceeds stored records");

    // scan index always runs ahead of the held position
    a_scan_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SCAN) |-> (r_j > r_i))
        else $error("scan index not beyond held entry");

    // a pending word is never overwritten before it is taken
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_ov && !o_out.ready) |=> (r_ov && $stable(r_orec)))
        else $error("pending output word lost");

endmodule

// ===== tb/exchange_sort_by_price_tb.sv =====
`timescale 1ns / 100ps
// testbench for exchange_sort_by_price: feeds goods lists, predicts the price-sorted
// output words with its own exchange sort, and checks every sorted word field by field
// depends on exsort_pkg, exsort_if and the exchange_sort_by_price rtl
module exchange_sort_by_price_tb;

    localparam int unsigned MAX_RECS     = 64;
    localparam int unsigned RESET_CYCLES = 11;
    localparam int unsigned ITEM_TARGET  = 360;
    localparam int unsigned CALM_FROM    = 300;
    localparam int unsigned SQUEEZE_AT   = 40;
    localparam int unsigned SQUEEZE_LEN  = 700;

    typedef struct packed {
        exsort_pkg::t_rec               rec;
        logic [exsort_pkg::TALLY_W-1:0] dec_count;
        logic                           ovf;
        logic                           eol;
    } t_sorted_word;

    // collects each list as it is loaded and queues the sorted words it must produce
    class price_sort_board;
        exsort_pkg::t_rec loading[$];
        int unsigned      dec_tally;
        bit               dropped;
        t_sorted_word     awaited[$];
        int unsigned      errors;
        int unsigned      words_seen;

        function void note_record(exsort_pkg::t_rec r, bit last);
            exsort_pkg::t_rec ordered[$];
            exsort_pkg::t_rec hold;
            t_sorted_word     w;
            if (loading.size() < MAX_RECS) begin
                loading.push_back(r);
                if (r.month == exsort_pkg::DECEMBER) dec_tally++;
            end else begin
                dropped = 1'b1;
            end
            if (!last) return;
            ordered = loading;
            // same pairwise sequence as the hardware, so ties land identically
            for (int i = 0; i < ordered.size(); i++) begin
                for (int j = i + 1; j < ordered.size(); j++) begin
                    if ($signed(ordered[i].price) > $signed(ordered[j].price)) begin
                        hold       = ordered[i];
                        ordered[i] = ordered[j];
                        ordered[j] = hold;
                    end
                end
            end
            foreach (ordered[k]) begin
                w.rec       = ordered[k];
                w.dec_count = dec_tally[exsort_pkg::TALLY_W-1:0];
                w.ovf       = dropped;
                w.eol       = (k == ordered.size() - 1);
                awaited.push_back(w);
            end
            loading.delete();
            dec_tally = 0;
            dropped   = 1'b0;
        endfunction

        function void compare_field(string what, logic [31:0] want_v, logic [31:0] got_v);
            if (got_v !== want_v) begin
                errors++;
                if (errors <= 10)
                    $display("word %0d: %s expected %0h, got %0h", words_seen, what,
                             want_v, got_v);
            end
        endfunction

        function void check_word(t_sorted_word got);
            t_sorted_word want;
            words_seen++;
            if (awaited.size() == 0) begin
                errors++;
                if (errors <= 10)
                    $display("word %0d: unexpected, price %0h tag %0h", words_seen,
                             got.rec.price, got.rec.tag);
                return;
            end
            want = awaited.pop_front();
            compare_field("price", want.rec.price, got.rec.price);
            compare_field("tag", 32'(want.rec.tag), 32'(got.rec.tag));
            compare_field("day", 32'(want.rec.day), 32'(got.rec.day));
            compare_field("month", 32'(want.rec.month), 32'(got.rec.month));
            compare_field("year", 32'(want.rec.year), 32'(got.rec.year));
            compare_field("december_count", 32'(want.dec_count), 32'(got.dec_count));
            compare_field("overflow", 32'(want.ovf), 32'(got.ovf));
            compare_field("end_of_list", 32'(want.eol), 32'(got.eol));
        endfunction
    endclass

    logic i_clk = 1'b0;
    logic i_rst_n;

    exsort_in_if  in_ch ();
    exsort_out_if out_ch ();

    exchange_sort_by_price #(
        .MAX_ITEMS(MAX_RECS)
    ) uut (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_in   (in_ch),
        .o_out  (out_ch)
    );

    price_sort_board board;
    int unsigned     items_sent = 0;
    bit              calm = 1'b0;

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    initial begin
        #4_000_000;
        $display("simulation failed");
        $finish;
    end

    // both channels are observed at the edge, before any new drive takes effect
    always @(posedge i_clk) begin : observe
        exsort_pkg::t_rec arrived;
        t_sorted_word     got;
        if (i_rst_n === 1'b1) begin
            if (in_ch.valid && in_ch.ready) begin
                arrived.price = in_ch.price;
                arrived.tag   = in_ch.tag;
                arrived.day   = in_ch.day;
                arrived.month = in_ch.month;
                arrived.year  = in_ch.year;
                board.note_record(arrived, in_ch.last_item);
            end
            if (out_ch.valid === 1'b1 && out_ch.ready) begin
                got.rec.price = out_ch.sorted_price;
                got.rec.tag   = out_ch.sorted_tag;
                got.rec.day   = out_ch.sorted_day;
                got.rec.month = out_ch.sorted_month;
                got.rec.year  = out_ch.sorted_year;
                got.dec_count = out_ch.december_count;
                got.ovf       = out_ch.overflow;
                got.eol       = out_ch.end_of_list;
                board.check_word(got);
            end
        end
    end

    // receiver: random stall bursts, quiet stretches, and one long hold-off
    initial begin : receiver
        int unsigned stall_left;
        int unsigned quiet_left;
        int unsigned roll;
        bit          squeezed;
        stall_left = 0;
        quiet_left = 0;
        squeezed   = 1'b0;
        out_ch.ready <= 1'b0;
        wait (i_rst_n === 1'b1);
        forever begin
            @(posedge i_clk);
            if (!squeezed && board.words_seen >= SQUEEZE_AT) begin
                squeezed   = 1'b1;
                stall_left = SQUEEZE_LEN;
            end else if (stall_left == 0 && quiet_left == 0 && !calm) begin
                roll = $urandom_range(0, 59);
                if (roll < 6)
                    stall_left = $urandom_range(1, 12);
                else if (roll == 6)
                    quiet_left = $urandom_range(40, 200);
            end
            if (stall_left != 0) begin
                out_ch.ready <= 1'b0;
                stall_left--;
            end else begin
                out_ch.ready <= 1'b1;
                if (quiet_left != 0) quiet_left--;
            end
        end
    end

    function automatic exsort_pkg::t_rec goods(logic [31:0] price, logic [15:0] tag,
                                               logic [4:0] day, logic [3:0] month,
                                               logic [13:0] year);
        exsort_pkg::t_rec r;
        r.price = price;
        r.tag   = tag;
        r.day   = day;
        r.month = month;
        r.year  = year;
        return r;
    endfunction

    // style 0: any price, style 1: whole units near zero (many ties), style 2: extremes mix
    function automatic exsort_pkg::t_rec rand_goods(int unsigned style);
        exsort_pkg::t_rec r;
        int unsigned      roll;
        case (style)
            0: r.price = $urandom;
            1: r.price = (int'($urandom_range(0, 8)) - 4) * 65536;
            default: begin
                roll = $urandom_range(0, 5);
                case (roll)
                    0: r.price = 32'h8000_0000;
                    1: r.price = 32'h7fff_ffff;
                    2: r.price = 32'h0000_0000;
                    3: r.price = 32'hffff_ffff;
                    default: r.price = $urandom;
                endcase
            end
        endcase
        r.tag = 16'($urandom_range(0, 65535));
        r.day = 5'($urandom_range(0, 31));
        roll  = $urandom_range(0, 19);
        if (roll < 5)
            r.month = exsort_pkg::DECEMBER;
        else if (roll < 18)
            r.month = 4'($urandom_range(1, 11));
        else
            r.month = 4'($urandom_range(0, 15));
        r.year = ($urandom_range(0, 9) < 8) ? 14'($urandom_range(0, 9999))
                                            : 14'($urandom_range(10000, 16383));
        return r;
    endfunction

    // valid stays high between back-to-back words; it only drops for a gap
    task automatic send_word(exsort_pkg::t_rec r, bit last, bit gaps_on);
        int unsigned gap;
        gap = 0;
        if (gaps_on && !calm && $urandom_range(0, 3) == 0)
            gap = $urandom_range(1, 12);
        if (gap != 0) begin
            in_ch.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        in_ch.valid     <= 1'b1;
        in_ch.price     <= r.price;
        in_ch.tag       <= r.tag;
        in_ch.day       <= r.day;
        in_ch.month     <= r.month;
        in_ch.year      <= r.year;
        in_ch.last_item <= last;
        do @(posedge i_clk); while (in_ch.ready !== 1'b1);
        items_sent++;
        if (items_sent >= CALM_FROM) calm = 1'b1;
    endtask

    task automatic send_list(exsort_pkg::t_rec recs[$], bit gaps_on);
        foreach (recs[k])
            send_word(recs[k], k == recs.size() - 1, gaps_on);
    endtask

    task automatic send_random_list(int unsigned count);
        exsort_pkg::t_rec batch[$];
        int unsigned      style;
        bit               gaps_on;
        style   = $urandom_range(0, 2);
        gaps_on = ($urandom_range(0, 2) != 0);
        repeat (count) batch.push_back(rand_goods(style));
        send_list(batch, gaps_on);
    endtask

    function automatic int unsigned pick_size();
        return ($urandom_range(0, 4) == 0) ? $urandom_range(9, 24) : $urandom_range(1, 8);
    endfunction

    initial begin : stimulus
        exsort_pkg::t_rec batch[$];
        board = new();
        i_rst_n         <= 1'b0;
        in_ch.valid     <= 1'b0;
        in_ch.price     <= '0;
        in_ch.tag       <= '0;
        in_ch.day       <= '0;
        in_ch.month     <= '0;
        in_ch.year      <= '0;
        in_ch.last_item <= 1'b0;
        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // single-record lists at the field extremes
        batch = '{goods(32'h7fff_ffff, 16'hffff, 5'd31, exsort_pkg::DECEMBER, 14'h3fff)};
        send_list(batch, 1'b1);
        batch = '{goods(32'h8000_0000, 16'h0000, 5'd0, 4'd0, 14'd0)};
        send_list(batch, 1'b1);

        // mixed signs, equal prices with distinct tags, months outside 1..12
        batch = '{goods(32'h7fff_ffff, 16'h0001, 5'd1, exsort_pkg::DECEMBER, 14'd9999),
                  goods(32'h8000_0000, 16'h0002, 5'd31, 4'd15, 14'd0),
                  goods(32'h0001_0000, 16'h0003, 5'd10, exsort_pkg::DECEMBER, 14'd2000),
                  goods(32'h0000_0000, 16'h0004, 5'd15, 4'd1, 14'd1999),
                  goods(32'hffff_ffff, 16'h0005, 5'd20, 4'd0, 14'h3fff),
                  goods(32'h0001_0000, 16'h0006, 5'd2, 4'd6, 14'd1234),
                  goods(32'h0000_0001, 16'h0007, 5'd3, exsort_pkg::DECEMBER, 14'd42),
                  goods(32'h8000_0001, 16'h0008, 5'd4, 4'd13, 14'd5000),
                  goods(32'h0001_0000, 16'h0009, 5'd5, 4'd11, 14'd7777),
                  goods(32'hffff_0000, 16'h000a, 5'd6, exsort_pkg::DECEMBER, 14'd100)};
        send_list(batch, 1'b0);

        // descending with one tie, forces many swaps
        batch = '{goods(32'h0005_0000, 16'h0101, 5'd7, 4'd2, 14'd1),
                  goods(32'h0004_0000, 16'h0102, 5'd8, 4'd3, 14'd2),
                  goods(32'h0003_0000, 16'h0103, 5'd9, 4'd4, 14'd3),
                  goods(32'h0003_0000, 16'h0104, 5'd11, 4'd5, 14'd4),
                  goods(32'h0001_0000, 16'h0105, 5'd12, 4'd7, 14'd5),
                  goods(32'hfffb_0000, 16'h0106, 5'd13, 4'd8, 14'd6)};
        send_list(batch, 1'b1);

        while (items_sent < 120) send_random_list(pick_size());
        // exactly full, then two records past capacity with both extra records dropped
        send_random_list(MAX_RECS);
        send_random_list(MAX_RECS + 2);
        while (items_sent < ITEM_TARGET) send_random_list(pick_size());

        in_ch.valid <= 1'b0;
        // let the observer note the final word before looking at the queue
        @(posedge i_clk);
        while (board.awaited.size() != 0) @(posedge i_clk);
        repeat (200) @(posedge i_clk);
        if (board.errors == 0 && board.awaited.size() == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule
